@@ rtl/i2cbb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C bit-bang master package
// Command codes, phase descriptor and the phase table of each command.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_RESTART = 3'd1,
        OP_WRITE   = 3'd2,
        OP_RD_ACK  = 3'd3,
        OP_RD_NACK = 3'd4,
        OP_STOP    = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        SMP_NONE = 2'd0,
        SMP_ACK  = 2'd1,
        SMP_DATA = 2'd2,
        SMP_WBIT = 2'd3
    } t_smp;

    typedef struct packed {
        logic vld;
        logic scl;
        logic sda;
        logic dbl;
        t_smp smp;
    } t_phase;

    localparam int BYTE_PHASES = 16;

    function automatic t_phase mk_ph(input logic scl, input logic sda,
                                     input logic dbl, input t_smp smp);
        t_phase ph;
        ph.vld = 1'b1;
        ph.scl = scl;
        ph.sda = sda;
        ph.dbl = dbl;
        ph.smp = smp;
        return ph;
    endfunction

    // Phase p of command op; vld low past the end of the sequence.
    function automatic t_phase phase_info(input t_op op, input logic [5:0] p,
                                          input logic b);
        t_phase     ph;
        logic [5:0] q;
        logic       a;
        ph = '{vld: 1'b0, scl: 1'b1, sda: 1'b1, dbl: 1'b0, smp: SMP_NONE};
        q  = p;
        a  = (op == OP_RD_NACK);
        unique case (op)
            OP_STOP: begin
                if (p == 6'd0)      ph = mk_ph(1'b1, 1'b0, 1'b0, SMP_NONE);
                else if (p == 6'd1) ph = mk_ph(1'b1, 1'b1, 1'b0, SMP_NONE);
            end
            OP_RD_ACK, OP_RD_NACK: begin
                if (p < 6'(BYTE_PHASES)) begin
                    if (!p[0]) ph = mk_ph(1'b1, 1'b1, 1'b1, SMP_DATA);
                    else       ph = mk_ph(1'b0, 1'b1, 1'b0, SMP_NONE);
                end else if (p == 6'd16) ph = mk_ph(1'b1, a, 1'b0, SMP_NONE);
                else if (p == 6'd17)     ph = mk_ph(1'b0, a, 1'b0, SMP_NONE);
            end
            default: begin
                if (op == OP_START) q = p - 6'd2;
                else if (op == OP_RESTART) q = p - 6'd4;
                if (op == OP_START && p == 6'd0)
                    ph = mk_ph(1'b1, 1'b0, 1'b0, SMP_NONE);
                else if (op == OP_START && p == 6'd1)
                    ph = mk_ph(1'b0, 1'b0, 1'b0, SMP_NONE);
                else if (op == OP_RESTART && p == 6'd0)
                    ph = mk_ph(1'b0, 1'b1, 1'b0, SMP_NONE);
                else if (op == OP_RESTART && p == 6'd1)
                    ph = mk_ph(1'b1, 1'b1, 1'b0, SMP_NONE);
                else if (op == OP_RESTART && p == 6'd2)
                    ph = mk_ph(1'b1, 1'b0, 1'b0, SMP_NONE);
                else if (op == OP_RESTART && p == 6'd3)
                    ph = mk_ph(1'b0, 1'b0, 1'b0, SMP_NONE);
                else if (q < 6'(BYTE_PHASES)) begin
                    if (!q[0]) ph = mk_ph(1'b1, b, 1'b0, SMP_NONE);
                    else       ph = mk_ph(1'b0, b, 1'b0, SMP_WBIT);
                end else if (q == 6'd16) ph = mk_ph(1'b0, 1'b1, 1'b0, SMP_NONE);
                else if (q == 6'd17)     ph = mk_ph(1'b1, 1'b1, 1'b0, SMP_ACK);
                else if (q == 6'd18)     ph = mk_ph(1'b0, 1'b1, 1'b0, SMP_NONE);
            end
        endcase
        return ph;
    endfunction

endpackage
`default_nettype wire

@@ rtl/i2c_bit_bang_master_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C bit-bang master unit
// Open-drain I2C master walking SCL/SDA phase by phase, one beat per step.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata 24b, tuser 4b
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata 16b
//  cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_data = half_period
//
// One beat per clock while m_axis does not stall; each beat passes the input
// register, then the step logic into the state and result registers.
// Synchronous active-low reset; half_period resets to 1.
// A stall on m_axis holds the result register, then the input register,
// then drops s_axis_tready. o_cfg_ready is always high.
// ----------------------------------------------------------------------------
module i2c_bit_bang_master_unit
    import i2cbb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // tick, slave_address[7:1], read_mode, write_data[16:9], sda_in, pad
    input  wire logic [23:0] s_axis_tdata,
    // cmd_valid, operation[3:1]
    input  wire logic [3:0]  s_axis_tuser,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // scl_release, sda_release, busy_res, done_res, read_data[11:4],
    // slave_nack, pad
    output      logic [15:0] m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data
);

    logic        r_in_vld;
    logic [17:0] r_in_data;
    logic [3:0]  r_in_user;
    logic        r_out_vld;
    logic [15:0] r_out_data;

    logic [7:0]  r_half;
    t_op         r_op,    n_op;
    logic [5:0]  r_phase, n_phase;
    logic [3:0]  r_bcnt,  n_bcnt;
    logic [7:0]  r_shift, n_shift;
    logic [8:0]  r_delay, n_delay;
    logic        r_busy,  n_busy;
    logic        r_scl,   n_scl;
    logic        r_sda,   n_sda;
    logic        r_ack,   n_ack;
    logic [7:0]  r_rxb,   n_rxb;
    logic        n_done;

    logic        s2_go;
    logic        in_tick, in_cmd, in_rd, in_sda;
    logic [2:0]  in_op;
    logic [6:0]  in_addr;
    logic [7:0]  in_wd;
    logic [7:0]  hp_eff;
    logic [8:0]  dec;
    logic [5:0]  np;
    t_phase      cur_ph, nxt_ph;

    assign s2_go         = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || s2_go;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    assign in_tick = r_in_data[0];
    assign in_addr = r_in_data[7:1];
    assign in_rd   = r_in_data[8];
    assign in_wd   = r_in_data[16:9];
    assign in_sda  = r_in_data[17];
    assign in_cmd  = r_in_user[0];
    assign in_op   = r_in_user[3:1];
    assign hp_eff  = (r_half == 8'd0) ? 8'd1 : r_half;
    assign dec     = (r_delay != 9'd0) ? r_delay - 9'd1 : 9'd0;
    assign np      = r_phase + 6'd1;

    always_comb begin
        n_op    = r_op;
        n_phase = r_phase;
        n_bcnt  = r_bcnt;
        n_shift = r_shift;
        n_delay = r_delay;
        n_busy  = r_busy;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_ack   = r_ack;
        n_rxb   = r_rxb;
        n_done  = 1'b0;
        cur_ph  = phase_info(r_op, r_phase, r_shift[7]);
        nxt_ph  = cur_ph;
        if (!r_busy) begin
            if (in_cmd && in_op <= OP_STOP) begin
                n_op    = t_op'(in_op);
                n_phase = 6'd0;
                n_bcnt  = 4'd0;
                if (in_op == OP_START || in_op == OP_RESTART) n_shift = {in_addr, in_rd};
                else if (in_op == OP_WRITE) n_shift = in_wd;
                else n_shift = 8'd0;
                n_busy  = 1'b1;
                nxt_ph  = phase_info(n_op, 6'd0, n_shift[7]);
                n_delay = nxt_ph.dbl ? {hp_eff, 1'b0} : {1'b0, hp_eff};
                n_scl   = nxt_ph.scl;
                n_sda   = nxt_ph.sda;
            end
        end else if (in_tick) begin
            n_delay = dec;
            if (dec == 9'd0) begin
                if (cur_ph.vld) begin
                    case (cur_ph.smp)
                        SMP_ACK:  n_ack = in_sda;
                        SMP_DATA: begin
                            n_shift = {r_shift[6:0], in_sda};
                            n_bcnt  = r_bcnt + 4'd1;
                        end
                        SMP_WBIT: begin
                            n_shift = {r_shift[6:0], 1'b0};
                            n_bcnt  = r_bcnt + 4'd1;
                        end
                        default: ;
                    endcase
                end
                n_phase = np;
                nxt_ph  = phase_info(r_op, np, n_shift[7]);
                if (nxt_ph.vld) begin
                    n_delay = nxt_ph.dbl ? {hp_eff, 1'b0} : {1'b0, hp_eff};
                    n_scl   = nxt_ph.scl;
                    n_sda   = nxt_ph.sda;
                end else begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                    if (r_op == OP_RD_ACK || r_op == OP_RD_NACK) n_rxb = n_shift;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_half    <= 8'd1;
            r_op      <= OP_STOP;
            r_phase   <= 6'd0;
            r_bcnt    <= 4'd0;
            r_shift   <= 8'd0;
            r_delay   <= 9'd0;
            r_busy    <= 1'b0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_ack     <= 1'b0;
            r_rxb     <= 8'd0;
        end else begin
            if (i_cfg_valid) r_half <= i_cfg_data;
            if (s_axis_tready) r_in_vld <= s_axis_tvalid;
            if (s2_go) begin
                r_out_vld <= 1'b1;
                r_op      <= n_op;
                r_phase   <= n_phase;
                r_bcnt    <= n_bcnt;
                r_shift   <= n_shift;
                r_delay   <= n_delay;
                r_busy    <= n_busy;
                r_scl     <= n_scl;
                r_sda     <= n_sda;
                r_ack     <= n_ack;
                r_rxb     <= n_rxb;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata[17:0];
            r_in_user <= s_axis_tuser;
        end
        if (s2_go) begin
            r_out_data <= {3'b000, n_ack, n_rxb, n_done, n_busy, n_sda, n_scl};
        end
    end

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_data[3] |-> !r_out_data[2])
        else $error("done beat reports busy");
    a_idle_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_delay == 9'd0)
        else $error("phase counter live while idle");
    a_delay_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_delay <= 9'd510)
        else $error("phase counter out of range");
    a_bcnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bcnt <= 4'd8)
        else $error("bit count past one byte");
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_go && !r_busy && !(r_in_user[0] && r_in_user[3:1] <= OP_STOP)
        |=> !r_busy)
        else $error("went busy without a command");
`endif

endmodule
`default_nettype wire
